/* design/avss_pkg.sv */
`timescale 1ns / 1ps
// Shared types and codes for the A/V sync startup sequencer.
// No dependencies.
package avss_pkg;

  localparam int unsigned KIND_W = 4;
  localparam int unsigned PHASE_W = 4;
  localparam int unsigned GEN_FIELD_W = 64;

  // Event kinds
  localparam logic [KIND_W-1:0] KIND_BEGIN         = 4'd0;
  localparam logic [KIND_W-1:0] KIND_REACQUIRE     = 4'd1;
  localparam logic [KIND_W-1:0] KIND_CLOCKS_LOCKED = 4'd2;
  localparam logic [KIND_W-1:0] KIND_PRIMED        = 4'd3;
  localparam logic [KIND_W-1:0] KIND_RELEASE       = 4'd4;
  localparam logic [KIND_W-1:0] KIND_RUN           = 4'd5;
  localparam logic [KIND_W-1:0] KIND_FAIL          = 4'd6;
  localparam logic [KIND_W-1:0] KIND_STOP          = 4'd7;
  localparam logic [KIND_W-1:0] KIND_ABORT         = 4'd8;
  localparam logic [KIND_W-1:0] KIND_CLEAR         = 4'd9;

  // Phases
  localparam logic [PHASE_W-1:0] PH_IDLE      = 4'd0;
  localparam logic [PHASE_W-1:0] PH_ACQUIRING = 4'd1;
  localparam logic [PHASE_W-1:0] PH_PRIMING   = 4'd2;
  localparam logic [PHASE_W-1:0] PH_ARMED     = 4'd3;
  localparam logic [PHASE_W-1:0] PH_RELEASED  = 4'd4;
  localparam logic [PHASE_W-1:0] PH_RUNNING   = 4'd5;
  localparam logic [PHASE_W-1:0] PH_FAILED    = 4'd6;
  localparam logic [PHASE_W-1:0] PH_STOPPED   = 4'd7;
  localparam logic [PHASE_W-1:0] PH_ABORTED   = 4'd8;

  // Status codes
  localparam logic ST_ACCEPT = 1'b0;
  localparam logic ST_REJECT = 1'b1;

  typedef struct packed {
    logic [KIND_W-1:0]      kind;
    logic [GEN_FIELD_W-1:0] event_generation;
  } avss_in_t;

  typedef struct packed {
    logic                   status;
    logic [PHASE_W-1:0]     phase;
    logic                   generation_present;
    logic [GEN_FIELD_W-1:0] held_generation_out;
  } avss_out_t;

endpackage

/* design/av_sync_startup_sequencer_unit.sv */
`timescale 1ns / 1ps
// A/V sync startup sequencer: event guard checks and phase/generation tracking.
// Depends on avss_pkg.
//
// Usage notes
// - Input channel (in_valid_i / in_stall_o / in_data_i): one event per transfer,
//   a kind code and a generation number (low GEN_WIDTH bits used).
// - Output channel (out_valid_o / out_stall_i / out_data_o): exactly one result
//   per event: accept/reject status, phase, held-generation flag and value.
// - Path: an event is held in the event register, and its result is then
//   loaded into the result register, which drives the output.
// - Throughput: one event per cycle unless the receiver stalls. The event register
//   feeds a single pass of guard logic; the phase/generation state and the result
//   register load together, so the next event sees the updated state without a bubble.
// - Receiver stall: the result register holds; the event register still takes
//   one more event, after which in_stall_o rises until the result is taken.
// - Reset (rst_ni low, asynchronous): phase idle, no generation held, held
//   value zero, both stages empty.
module av_sync_startup_sequencer_unit
  import avss_pkg::*;
#(
  parameter int unsigned GEN_WIDTH = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  avss_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output avss_out_t out_data_o
);

  // Event register stage
  logic                 ev_valid_q;
  logic [KIND_W-1:0]    ev_kind_q;
  logic [GEN_WIDTH-1:0] ev_gen_q;

  // Sequencer state
  logic [PHASE_W-1:0]   phase_q, phase_d;
  logic [GEN_WIDTH-1:0] held_gen_q, held_gen_d;
  logic                 held_flag_q, held_flag_d;

  // Result register
  logic      out_valid_q;
  avss_out_t out_data_q;

  logic advance;   // event stage moves into the result register
  logic ev_load;
  logic ok;
  logic terminal;
  logic gen_match;

  assign advance    = ev_valid_q && (!out_valid_q || !out_stall_i);
  assign ev_load    = !ev_valid_q || advance;
  assign in_stall_o = !ev_load;

  assign terminal  = (phase_q == PH_FAILED) || (phase_q == PH_STOPPED) ||
                     (phase_q == PH_ABORTED);
  assign gen_match = held_flag_q && (ev_gen_q == held_gen_q);

  // Guard checks and next state; rejected events leave the state alone
  always_comb begin
    ok          = 1'b0;
    phase_d     = phase_q;
    held_gen_d  = held_gen_q;
    held_flag_d = held_flag_q;
    case (ev_kind_q)
      KIND_CLEAR: begin
        ok          = 1'b1;
        phase_d     = PH_IDLE;
        held_gen_d  = '0;
        held_flag_d = 1'b0;
      end
      KIND_BEGIN: begin
        if (phase_q == PH_IDLE && !held_flag_q) begin
          ok          = 1'b1;
          phase_d     = PH_ACQUIRING;
          held_gen_d  = ev_gen_q;
          held_flag_d = 1'b1;
        end
      end
      KIND_REACQUIRE: begin
        if (held_flag_q && (ev_gen_q >= held_gen_q) && !terminal) begin
          ok         = 1'b1;
          phase_d    = PH_ACQUIRING;
          held_gen_d = ev_gen_q;
        end
      end
      KIND_CLOCKS_LOCKED: begin
        if (gen_match && phase_q == PH_ACQUIRING) begin
          ok      = 1'b1;
          phase_d = PH_PRIMING;
        end
      end
      KIND_PRIMED: begin
        if (gen_match && phase_q == PH_PRIMING) begin
          ok      = 1'b1;
          phase_d = PH_ARMED;
        end
      end
      KIND_RELEASE: begin
        if (gen_match && phase_q == PH_ARMED) begin
          ok      = 1'b1;
          phase_d = PH_RELEASED;
        end
      end
      KIND_RUN: begin
        if (gen_match && phase_q == PH_RELEASED) begin
          ok      = 1'b1;
          phase_d = PH_RUNNING;
        end
      end
      KIND_FAIL: begin
        if (gen_match && !terminal) begin
          ok      = 1'b1;
          phase_d = PH_FAILED;
        end
      end
      KIND_STOP: begin
        if (gen_match && phase_q != PH_ABORTED) begin
          ok      = 1'b1;
          phase_d = PH_STOPPED;
        end
      end
      KIND_ABORT: begin
        if (gen_match) begin
          ok      = 1'b1;
          phase_d = PH_ABORTED;
        end
      end
      default: begin
        ok = 1'b0;  // undefined kinds are rejected
      end
    endcase
  end

  // Event stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ev_valid_q <= 1'b0;
    end else if (ev_load) begin
      ev_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ev_load && in_valid_i) begin
      ev_kind_q <= in_data_i.kind;
      ev_gen_q  <= in_data_i.event_generation[GEN_WIDTH-1:0];
    end
  end

  // State and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      held_gen_q  <= '0;
      held_flag_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        phase_q     <= phase_d;
        held_gen_q  <= held_gen_d;
        held_flag_q <= held_flag_d;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q.status              <= ok ? ST_ACCEPT : ST_REJECT;
      out_data_q.phase               <= phase_d;
      out_data_q.generation_present  <= held_flag_d;
      out_data_q.held_generation_out <= held_flag_d ? GEN_FIELD_W'(held_gen_d)
                                                     : '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // Checks
  a_reject_holds_state : assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && !ok |=> $stable(phase_q) && $stable(held_flag_q) && $stable(held_gen_q))
    else $error("rejected event changed sequencer state");

  a_advance_fills_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("event advanced without a result");

  a_no_gen_is_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !held_flag_q |-> held_gen_q == '0)
    else $error("held generation non-zero with no generation held");

  a_phase_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q <= PH_ABORTED)
    else $error("phase out of range");

  a_stalled_result_kept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i |=> out_valid_q && $stable(out_data_q))
    else $error("stalled result lost or changed");

endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps
// Self-checking bench for av_sync_startup_sequencer_unit: a directed event table,
// then random event streams, scored against typed-in results or a behavioural model of the phases.
// Depends on avss_pkg and the unit under test.
module testbench;
  import avss_pkg::*;

  localparam int unsigned GEN_WIDTH = 64;
  // Low GEN_WIDTH bits of a generation are the only ones the unit looks at.
  localparam logic [GEN_FIELD_W-1:0] GEN_MASK = {GEN_FIELD_W{1'b1}} >> (GEN_FIELD_W - GEN_WIDTH);
  localparam logic [GEN_FIELD_W-1:0] GEN_ZERO = '0;
  localparam logic [GEN_FIELD_W-1:0] GEN_ONES = '1;
  localparam logic [GEN_FIELD_W-1:0] GEN_TOP  = {1'b1, {(GEN_FIELD_W-1){1'b0}}};

  // Kind codes the unit does not define; both must come back rejected.
  localparam logic [KIND_W-1:0] KIND_UNDEF_FIRST = 4'd10;
  localparam logic [KIND_W-1:0] KIND_UNDEF_LAST  = 4'd15;

  localparam int unsigned NUM_DIRECTED  = 25;
  localparam int unsigned RANDOM_ITEMS  = 850;
  localparam int unsigned STRETCH_LEN   = 50;   // items per idling pattern
  localparam int unsigned PRESSURE_AT   = 400;  // stretch that gets the long hold
  localparam int unsigned LONG_HOLD     = 60;   // receiver hold-off, cycles
  localparam int unsigned DRAIN_CYCLES  = 10;
  localparam int unsigned OUT_W         = $bits(avss_out_t);

  // One row of the directed table. A typed-in row carries its result; the
  // rest are scored against the model.
  typedef struct packed {
    avss_in_t  ev;
    logic      typed;
    avss_out_t result;
  } stim_row_t;

  localparam logic      TYPED     = 1'b1;
  localparam logic      BY_MODEL  = 1'b0;
  localparam avss_out_t NO_RESULT = '0;

  logic      clk_i = 1'b0;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  avss_in_t  in_data_i;
  logic      out_valid_o;
  logic      out_stall_i;
  avss_out_t out_data_o;

  // Model state: phase, held generation and whether one is held.
  logic [PHASE_W-1:0]     model_phase;
  logic                   model_has_gen;
  logic [GEN_FIELD_W-1:0] model_gen;

  avss_out_t   due_results[$];   // results still owed by the unit, oldest first
  int unsigned mismatches;
  bit          send_idle;        // sender inserts random gaps
  bit          recv_idle;        // receiver inserts random stalls
  bit          hold_request;     // ask the receiver for one long hold-off

  // Directed walk: reset state, every kind, undefined kinds, generation
  // extremes, phase guards, the terminal phases and clear.
  stim_row_t directed_rows [NUM_DIRECTED] = '{
    // nothing held after reset: run, reacquire and an undefined kind bounce
    {{KIND_RUN,          GEN_ZERO},   TYPED, {ST_REJECT, PH_IDLE, 1'b0, GEN_ZERO}},
    {{KIND_REACQUIRE,    64'd5},      TYPED, {ST_REJECT, PH_IDLE, 1'b0, GEN_ZERO}},
    {{KIND_UNDEF_LAST,   GEN_ONES},   TYPED, {ST_REJECT, PH_IDLE, 1'b0, GEN_ZERO}},
    // begin with the largest generation, then a second begin is refused
    {{KIND_BEGIN,        GEN_ONES},   TYPED, {ST_ACCEPT, PH_ACQUIRING, 1'b1, GEN_ONES}},
    {{KIND_BEGIN,        GEN_ZERO},   TYPED, {ST_REJECT, PH_ACQUIRING, 1'b1, GEN_ONES}},
    // wrong generation, and a reacquire that goes backwards
    {{KIND_CLOCKS_LOCKED, GEN_ZERO},  TYPED, {ST_REJECT, PH_ACQUIRING, 1'b1, GEN_ONES}},
    {{KIND_REACQUIRE,    GEN_ZERO},   TYPED, {ST_REJECT, PH_ACQUIRING, 1'b1, GEN_ONES}},
    {{KIND_REACQUIRE,    GEN_ONES},   BY_MODEL, NO_RESULT},
    // the normal climb, with one out-of-order release on the way
    {{KIND_CLOCKS_LOCKED, GEN_ONES},  BY_MODEL, NO_RESULT},
    {{KIND_RELEASE,      GEN_ONES},   BY_MODEL, NO_RESULT},
    {{KIND_PRIMED,       GEN_ONES},   BY_MODEL, NO_RESULT},
    {{KIND_RELEASE,      GEN_ONES},   BY_MODEL, NO_RESULT},
    {{KIND_RUN,          GEN_ONES},   BY_MODEL, NO_RESULT},
    // terminal phases: fail, then stop, then abort, and what each refuses
    {{KIND_FAIL,         GEN_ONES},   BY_MODEL, NO_RESULT},
    {{KIND_REACQUIRE,    GEN_ONES},   BY_MODEL, NO_RESULT},
    {{KIND_FAIL,         GEN_ONES},   BY_MODEL, NO_RESULT},
    {{KIND_STOP,         GEN_ONES},   BY_MODEL, NO_RESULT},
    {{KIND_ABORT,        GEN_ONES},   BY_MODEL, NO_RESULT},
    {{KIND_STOP,         GEN_ONES},   BY_MODEL, NO_RESULT},
    {{KIND_ABORT,        GEN_ONES},   BY_MODEL, NO_RESULT},
    {{KIND_UNDEF_FIRST,  GEN_ONES},   BY_MODEL, NO_RESULT},
    // clear ignores its generation and drops everything
    {{KIND_CLEAR,        GEN_ONES},   TYPED, {ST_ACCEPT, PH_IDLE, 1'b0, GEN_ZERO}},
    {{KIND_BEGIN,        GEN_ZERO},   BY_MODEL, NO_RESULT},
    {{KIND_REACQUIRE,    GEN_TOP},    BY_MODEL, NO_RESULT},
    {{KIND_CLEAR,        GEN_ZERO},   TYPED, {ST_ACCEPT, PH_IDLE, 1'b0, GEN_ZERO}}
  };

  av_sync_startup_sequencer_unit #(
    .GEN_WIDTH(GEN_WIDTH)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  // 2 ns period.
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic bit phase_is_terminal(input logic [PHASE_W-1:0] ph);
    return ph == PH_FAILED || ph == PH_STOPPED || ph == PH_ABORTED;
  endfunction

  // Applies one event to the model state and returns the result the unit owes.
  // A refused event leaves the state alone and reports it unchanged.
  function automatic avss_out_t sequencer_step(input avss_in_t ev);
    logic [GEN_FIELD_W-1:0] gen;
    logic                   gen_match;
    logic                   ok;
    avss_out_t              res;
    gen       = ev.event_generation & GEN_MASK;
    gen_match = model_has_gen && gen == model_gen;
    ok        = 1'b0;
    case (ev.kind)
      KIND_CLEAR: begin
        model_phase   = PH_IDLE;
        model_gen     = '0;
        model_has_gen = 1'b0;
        ok            = 1'b1;
      end
      KIND_BEGIN: begin
        ok = model_phase == PH_IDLE && !model_has_gen;
        if (ok) begin
          model_gen     = gen;
          model_has_gen = 1'b1;
          model_phase   = PH_ACQUIRING;
        end
      end
      KIND_REACQUIRE: begin
        ok = model_has_gen && gen >= model_gen && !phase_is_terminal(model_phase);
        if (ok) begin
          model_gen   = gen;
          model_phase = PH_ACQUIRING;
        end
      end
      KIND_CLOCKS_LOCKED: begin
        ok = gen_match && model_phase == PH_ACQUIRING;
        if (ok) model_phase = PH_PRIMING;
      end
      KIND_PRIMED: begin
        ok = gen_match && model_phase == PH_PRIMING;
        if (ok) model_phase = PH_ARMED;
      end
      KIND_RELEASE: begin
        ok = gen_match && model_phase == PH_ARMED;
        if (ok) model_phase = PH_RELEASED;
      end
      KIND_RUN: begin
        ok = gen_match && model_phase == PH_RELEASED;
        if (ok) model_phase = PH_RUNNING;
      end
      KIND_FAIL: begin
        ok = gen_match && !phase_is_terminal(model_phase);
        if (ok) model_phase = PH_FAILED;
      end
      KIND_STOP: begin
        ok = gen_match && model_phase != PH_ABORTED;
        if (ok) model_phase = PH_STOPPED;
      end
      KIND_ABORT: begin
        ok = gen_match;
        if (ok) model_phase = PH_ABORTED;
      end
      default: ok = 1'b0;
    endcase
    res.status              = ok ? ST_ACCEPT : ST_REJECT;
    res.phase               = model_phase;
    res.generation_present  = model_has_gen;
    res.held_generation_out = model_has_gen ? (model_gen & GEN_MASK) : '0;
    return res;
  endfunction

  // Random event generator. Mostly the next legal step for the current phase
  // with the held generation, so runs climb all the way to running; a fifth
  // is noise: any kind code with an arbitrary, off-by-one or held generation.
  function automatic avss_in_t pick_event();
    avss_in_t               ev;
    logic [GEN_FIELD_W-1:0] rnd;
    int unsigned            roll;
    rnd  = {$urandom, $urandom};
    roll = $urandom_range(0, 99);
    ev.event_generation = model_gen;
    if (roll < 20) begin
      ev.kind = KIND_W'($urandom_range(0, 15));
      case ($urandom_range(0, 3))
        0:       ev.event_generation = rnd;
        1:       ev.event_generation = model_gen - 1;
        2:       ev.event_generation = model_gen + 1;
        default: ev.event_generation = model_gen;
      endcase
    end else if (!model_has_gen) begin
      ev.kind = KIND_BEGIN;
      ev.event_generation = ($urandom_range(0, 3) == 0) ? rnd
                                                         : GEN_FIELD_W'($urandom_range(0, 1000));
    end else if (phase_is_terminal(model_phase)) begin
      // mostly tidy up; now and then push a terminal phase further along
      case ($urandom_range(0, 5))
        0:       ev.kind = KIND_STOP;
        1:       ev.kind = KIND_ABORT;
        default: begin
          ev.kind             = KIND_CLEAR;
          ev.event_generation = rnd;
        end
      endcase
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 65) begin
        case (model_phase)
          PH_ACQUIRING: ev.kind = KIND_CLOCKS_LOCKED;
          PH_PRIMING:   ev.kind = KIND_PRIMED;
          PH_ARMED:     ev.kind = KIND_RELEASE;
          PH_RELEASED:  ev.kind = KIND_RUN;
          default: begin
            case ($urandom_range(0, 3))
              0:       ev.kind = KIND_FAIL;
              1:       ev.kind = KIND_STOP;
              2:       ev.kind = KIND_ABORT;
              default: ev.kind = KIND_CLEAR;
            endcase
          end
        endcase
      end else if (roll < 82) begin
        // same or a slightly newer generation; wraps past the top now and then
        ev.kind             = KIND_REACQUIRE;
        ev.event_generation = model_gen + GEN_FIELD_W'($urandom_range(0, 2));
      end else if (roll < 94) begin
        case ($urandom_range(0, 2))
          0:       ev.kind = KIND_FAIL;
          1:       ev.kind = KIND_STOP;
          default: ev.kind = KIND_ABORT;
        endcase
      end else begin
        ev.kind = KIND_CLEAR;
      end
    end
    return ev;
  endfunction

  task automatic report_mismatch(input string what,
                                 input logic [OUT_W-1:0] want,
                                 input logic [OUT_W-1:0] got);
    mismatches++;
    $display("%0t ns: %s mismatch, expected %0h, got %0h", $realtime, what, want, got);
  endtask

  // Scores one result transfer against the oldest outstanding result.
  task automatic check_result(input avss_out_t got);
    avss_out_t want;
    if (due_results.size() == 0) begin
      report_mismatch("unexpected result", NO_RESULT, got);
      return;
    end
    want = due_results.pop_front();
    if (got.status !== want.status)
      report_mismatch("status", OUT_W'(want.status), OUT_W'(got.status));
    if (got.phase !== want.phase)
      report_mismatch("phase", OUT_W'(want.phase), OUT_W'(got.phase));
    if (got.generation_present !== want.generation_present)
      report_mismatch("generation_present", OUT_W'(want.generation_present),
                      OUT_W'(got.generation_present));
    if (got.held_generation_out !== want.held_generation_out)
      report_mismatch("held_generation_out", OUT_W'(want.held_generation_out),
                      OUT_W'(got.held_generation_out));
  endtask

  // Offers one event, starting at a falling edge. An optional gap drops valid
  // first; the payload then holds until the transfer, and the model is stepped
  // at that edge. Returns at the next falling edge with valid still high.
  task automatic send_event(input avss_in_t ev, input logic typed, input avss_out_t typed_result);
    int unsigned gap;
    avss_out_t   predicted;
    gap = send_idle ? $urandom_range(0, 9) : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= ev;
    do @(posedge clk_i); while (in_stall_o);
    predicted = sequencer_step(ev);
    due_results.push_back(typed ? typed_result : predicted);
    @(negedge clk_i);
  endtask

  // Result side. Before each transfer the receiver stalls for a drawn number
  // of cycles (or the long hold once it is asked for), then waits with stall
  // low for valid. The long hold is counted here, independent of the sender.
  initial begin : result_sink
    int unsigned wait_cycles;
    bit          hold_done;
    out_stall_i = 1'b0;
    hold_done   = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (hold_request && !hold_done) begin
        wait_cycles = LONG_HOLD;
        hold_done   = 1'b1;
      end else begin
        wait_cycles = recv_idle ? $urandom_range(0, 9) : 0;
      end
      if (wait_cycles != 0) begin
        out_stall_i <= 1'b1;
        repeat (wait_cycles) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      check_result(out_data_o);
      @(negedge clk_i);
    end
  end

  initial begin : stimulus
    int unsigned n;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    in_data_i     = '0;
    model_phase   = PH_IDLE;
    model_gen     = '0;
    model_has_gen = 1'b0;
    mismatches    = 0;
    send_idle     = 1'b1;
    recv_idle     = 1'b1;
    hold_request  = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i])
      send_event(directed_rows[i].ev, directed_rows[i].typed, directed_rows[i].result);

    // Random part in stretches: each stretch picks which side idles, so some
    // run back to back on both sides. One stretch has the sender flat out
    // while the receiver holds off, which fills both stages and stalls input.
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % STRETCH_LEN == 0) begin
        case ($urandom_range(0, 3))
          0: begin send_idle = 1'b1; recv_idle = 1'b1; end
          1: begin send_idle = 1'b1; recv_idle = 1'b0; end
          2: begin send_idle = 1'b0; recv_idle = 1'b1; end
          default: begin send_idle = 1'b0; recv_idle = 1'b0; end
        endcase
        if (n == PRESSURE_AT) begin
          send_idle    = 1'b0;
          hold_request = 1'b1;
        end
      end
      send_event(pick_event(), BY_MODEL, NO_RESULT);
    end
    in_valid_i <= 1'b0;

    // Wait for every owed result, then keep watching for stray transfers.
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin : watchdog
    #1_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
